@@ src/life_automaton_stencil_macros.svh @@
// ----------------------------------------------------------------------------
// Life automaton stencil assertion macros
// Shared concurrent assertion forms used by the stencil RTL.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_STENCIL_MACROS_SVH
`define LIFE_AUTOMATON_STENCIL_MACROS_SVH

// same-cycle implication
`define LAC_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LAC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lac_pkg.sv @@
// ----------------------------------------------------------------------------
// Life automaton stencil package
// Types and fixed constants shared by the stencil modules.
// ----------------------------------------------------------------------------
package lac_pkg;

    localparam int DIM_W       = 11;   // grid_width / grid_height register width
    localparam int ROW_W       = 10;   // row counter, height capped at 1024
    localparam int CFG_IDX_W   = 2;
    localparam int MIN_DIM     = 3;
    localparam int HEIGHT_CAP  = 1024;
    localparam int FIRST_INNER = 2;    // first row/column whose window is full
    localparam int WIN_W       = 9;
    localparam int CENTER_BIT  = 4;
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef logic [DIM_W-1:0]     dim_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [QPTR_W-1:0]    qptr_t;
    typedef logic [QCNT_W-1:0]    qcnt_t;
    typedef logic [3:0]           ncount_t;

    localparam cfg_idx_t REG_GRID_WIDTH  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_GRID_HEIGHT = cfg_idx_t'(1);

    // per-cell word handed from the front to the back
    typedef struct packed {
        logic alive_now;   // incoming cell state
        logic emit;        // window is centered on an interior cell
        logic last;        // last interior cell of the frame
    } lac_flags_t;

endpackage

@@ src/life_automaton_stencil.sv @@
// ----------------------------------------------------------------------------
// Life automaton stencil
// One B3/S23 generation over a padded raster grid, one cell per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Feed the padded grid (border ring included) in raster order, one cell per
// word; a result word comes out for each interior cell only, in raster order,
// with m_frame_last set on the last interior cell. While the output is not
// stalled the block sustains one cell per clock: the line store is a single
// memory with one read and one write port, read when a cell enters the
// stencil stage and written when it retires; a result goes through the queue,
// stencil stage and result register. A four-word queue lets the front end keep
// taking cells while the output stalls. Writing grid_width or grid_height
// restarts the frame at row 0, column 0; sizes are clamped to 3..MAX_WIDTH
// columns and 3..1024 rows. Write configuration only while the block is idle.
module life_automaton_stencil #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  lac_pkg::cfg_idx_t  cfg_index,
    input  lac_pkg::dim_t      cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cell_alive,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_next_alive,
    output logic               m_frame_last
);

    localparam int ADDR_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int FLG_W  = $bits(lac_pkg::lac_flags_t);
    localparam int QW     = ADDR_W + FLG_W;

    logic                 push;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [ADDR_W-1:0]    f_col;
    lac_pkg::lac_flags_t  f_flags;
    logic [QW-1:0]        q_rd_data;
    lac_pkg::lac_flags_t  q_flags;
    logic [ADDR_W-1:0]    q_col;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    lac_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push_i    (push),
        .cell_i    (s_cell_alive),
        .col_o     (f_col),
        .flags_o   (f_flags)
    );

    lac_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_i    (push),
        .wr_data_i ({f_col, f_flags}),
        .full_o    (q_full),
        .pop_i     (q_pop),
        .valid_o   (q_valid),
        .rd_data_o (q_rd_data)
    );

    assign q_col   = q_rd_data[QW-1:FLG_W];
    assign q_flags = lac_pkg::lac_flags_t'(q_rd_data[FLG_W-1:0]);

    lac_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid_i      (q_valid),
        .q_col_i        (q_col),
        .q_flags_i      (q_flags),
        .q_pop_o        (q_pop),
        .m_valid_o      (m_valid),
        .m_ready_i      (m_ready),
        .m_next_alive_o (m_next_alive),
        .m_frame_last_o (m_frame_last)
    );

endmodule

@@ src/lac_front.sv @@
// ----------------------------------------------------------------------------
// Life automaton stencil front end
// Holds the grid size registers and the raster position, and tags each cell.
// ----------------------------------------------------------------------------
module lac_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int ADDR_W    = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  lac_pkg::cfg_idx_t     cfg_index,
    input  lac_pkg::dim_t         cfg_wdata,
    input  logic                  push_i,
    input  logic                  cell_i,
    output logic [ADDR_W-1:0]     col_o,
    output lac_pkg::lac_flags_t   flags_o
);

    `include "life_automaton_stencil_macros.svh"

    lac_pkg::dim_t       width_reg;
    lac_pkg::dim_t       height_reg;
    lac_pkg::dim_t       w_eff;
    lac_pkg::dim_t       h_eff;
    logic [ADDR_W-1:0]   col_reg;
    logic [ADDR_W-1:0]   col_next;
    lac_pkg::row_t       row_reg;
    lac_pkg::row_t       row_next;
    logic                col_last;
    logic                row_last;

    // clamp the programmed size into the supported range
    always_comb begin
        if (width_reg < lac_pkg::dim_t'(lac_pkg::MIN_DIM)) begin
            w_eff = lac_pkg::dim_t'(lac_pkg::MIN_DIM);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = lac_pkg::dim_t'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg < lac_pkg::dim_t'(lac_pkg::MIN_DIM)) begin
            h_eff = lac_pkg::dim_t'(lac_pkg::MIN_DIM);
        end else if (32'(height_reg) > lac_pkg::HEIGHT_CAP) begin
            h_eff = lac_pkg::dim_t'(lac_pkg::HEIGHT_CAP);
        end else begin
            h_eff = height_reg;
        end
    end

    assign col_last = (32'(col_reg) == 32'(w_eff) - 32'd1);
    assign row_last = (32'(row_reg) == 32'(h_eff) - 32'd1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_last) begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + lac_pkg::row_t'(1);
        end else begin
            col_next = col_reg + ADDR_W'(1);
        end
    end

    assign col_o             = col_reg;
    assign flags_o.alive_now = cell_i;
    assign flags_o.emit      = (32'(row_reg) >= lac_pkg::FIRST_INNER) &&
                               (32'(col_reg) >= lac_pkg::FIRST_INNER);
    assign flags_o.last      = row_last && col_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= lac_pkg::dim_t'(23);
            height_reg <= lac_pkg::dim_t'(23);
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_we) begin
            // a write to grid_width or grid_height restarts the frame
            case (cfg_index)
                lac_pkg::REG_GRID_WIDTH: begin
                    width_reg <= cfg_wdata;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                lac_pkg::REG_GRID_HEIGHT: begin
                    height_reg <= cfg_wdata;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default: begin
                end
            endcase
        end else if (push_i) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    `LAC_ASSERT_NEXT(a_cfg_restart, aclk, aresetn,
        cfg_we && (cfg_index == lac_pkg::REG_GRID_WIDTH ||
                   cfg_index == lac_pkg::REG_GRID_HEIGHT),
        col_reg == '0 && row_reg == '0, "frame not restarted by config write")

endmodule

@@ src/lac_queue.sv @@
// ----------------------------------------------------------------------------
// Life automaton stencil queue
// Short FIFO that decouples the front end from the stencil back end.
// ----------------------------------------------------------------------------
module lac_queue #(
    parameter int W = 13
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_i,
    input  logic [W-1:0]  wr_data_i,
    output logic          full_o,
    input  logic          pop_i,
    output logic          valid_o,
    output logic [W-1:0]  rd_data_o
);

    `include "life_automaton_stencil_macros.svh"

    logic [W-1:0]   mem_reg [lac_pkg::QDEPTH];
    lac_pkg::qptr_t wr_ptr_reg;
    lac_pkg::qptr_t rd_ptr_reg;
    lac_pkg::qcnt_t count_reg;
    lac_pkg::qcnt_t count_next;

    assign full_o    = (count_reg == lac_pkg::qcnt_t'(lac_pkg::QDEPTH));
    assign valid_o   = (count_reg != '0);
    assign rd_data_o = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push_i && !pop_i) begin
            count_next = count_reg + lac_pkg::qcnt_t'(1);
        end else if (pop_i && !push_i) begin
            count_next = count_reg - lac_pkg::qcnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            mem_reg[wr_ptr_reg] <= wr_data_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_i) begin
                wr_ptr_reg <= wr_ptr_reg + lac_pkg::qptr_t'(1);
            end
            if (pop_i) begin
                rd_ptr_reg <= rd_ptr_reg + lac_pkg::qptr_t'(1);
            end
            count_reg <= count_next;
        end
    end

    `LAC_ASSERT_IMPLY(a_q_bound, aclk, aresetn, 1'b1,
        count_reg <= lac_pkg::qcnt_t'(lac_pkg::QDEPTH), "queue count past depth")
    `LAC_ASSERT_IMPLY(a_q_ptrs, aclk, aresetn, count_reg == '0,
        wr_ptr_reg == rd_ptr_reg, "empty queue with split pointers")

endmodule

@@ src/lac_back.sv @@
// ----------------------------------------------------------------------------
// Life automaton stencil back end
// Line store, 3x3 window, B3/S23 rule and the result register.
// ----------------------------------------------------------------------------
module lac_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int ADDR_W    = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid_i,
    input  logic [ADDR_W-1:0]    q_col_i,
    input  lac_pkg::lac_flags_t  q_flags_i,
    output logic                 q_pop_o,
    output logic                 m_valid_o,
    input  logic                 m_ready_i,
    output logic                 m_next_alive_o,
    output logic                 m_frame_last_o
);

    `include "life_automaton_stencil_macros.svh"

    // bit 1 holds the upper line, bit 0 the middle line
    logic [1:0]                  line_mem [MAX_WIDTH];
    logic [1:0]                  rd_reg;
    logic                        b_valid_reg;
    logic                        b_valid_next;
    lac_pkg::lac_flags_t         b_flags_reg;
    logic [ADDR_W-1:0]           b_col_reg;
    logic [lac_pkg::WIN_W-1:0]   win_reg;
    logic [lac_pkg::WIN_W-1:0]   win_next;
    lac_pkg::ncount_t            neigh;
    logic                        alive;
    logic                        out_free;
    logic                        b_fire;
    logic                        b_ready;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic                        m_next_alive_reg;
    logic                        m_frame_last_reg;

    assign out_free = !m_valid_reg || m_ready_i;
    // border cells need no output slot
    assign b_fire   = b_valid_reg && (!b_flags_reg.emit || out_free);
    assign b_ready  = !b_valid_reg || b_fire;
    assign q_pop_o  = q_valid_i && b_ready;

    // shift each window row left and insert the new column
    always_comb begin
        win_next = '0;
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = rd_reg[1];
        win_next[5] = rd_reg[0];
        win_next[8] = b_flags_reg.alive_now;
    end

    always_comb begin
        neigh = '0;
        for (int i = 0; i < lac_pkg::WIN_W; i++) begin
            if (i != lac_pkg::CENTER_BIT) begin
                neigh = neigh + lac_pkg::ncount_t'(win_next[i]);
            end
        end
        alive = (neigh == lac_pkg::ncount_t'(lac_pkg::BIRTH_COUNT)) ||
                (win_next[lac_pkg::CENTER_BIT] &&
                 neigh == lac_pkg::ncount_t'(lac_pkg::SURVIVE_COUNT));
    end

    assign b_valid_next = q_pop_o || (b_valid_reg && !b_fire);
    assign m_valid_next = (b_fire && b_flags_reg.emit) || (m_valid_reg && !m_ready_i);

    // read on pop, write back {middle, new} when the cell retires
    always_ff @(posedge aclk) begin
        if (q_pop_o) begin
            rd_reg <= line_mem[q_col_i];
        end
        if (b_fire) begin
            line_mem[b_col_reg] <= {rd_reg[0], b_flags_reg.alive_now};
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop_o) begin
            b_flags_reg <= q_flags_i;
            b_col_reg   <= q_col_i;
        end
        if (b_fire && b_flags_reg.emit) begin
            m_next_alive_reg <= alive;
            m_frame_last_reg <= b_flags_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            win_reg     <= '0;
        end else begin
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
            if (b_fire) begin
                win_reg <= win_next;
            end
        end
    end

    assign m_valid_o      = m_valid_reg;
    assign m_next_alive_o = m_next_alive_reg;
    assign m_frame_last_o = m_frame_last_reg;

    `LAC_ASSERT_NEXT(a_result_load, aclk, aresetn, b_fire && b_flags_reg.emit,
        m_valid_reg && m_next_alive_reg == $past(alive), "result not loaded")
    `LAC_ASSERT_IMPLY(a_last_inner, aclk, aresetn, b_valid_reg && b_flags_reg.last,
        b_flags_reg.emit, "frame end tagged on a border cell")

endmodule

@@ test/life_generation_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life stencil generation checker
// Watches the register port and both word channels of the stencil, keeps a
// private copy of the line stores, the 3x3 window and the raster position,
// works out the next state of every interior cell and compares each result
// word against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module life_generation_checker #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  lac_pkg::cfg_idx_t  cfg_index,
    input  lac_pkg::dim_t      cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_cell_alive,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_next_alive,
    input  logic               m_frame_last,
    output int                 mismatches,
    output int                 outstanding,
    output int                 results_checked
);

    localparam int MIN_SIDE       = 3;
    localparam int ROWS_MAX       = 1024;
    localparam int SIDE_AT_RESET  = 23;
    localparam int BORN_AT        = 3;
    localparam int KEEP_AT        = 2;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        logic next_alive;
        logic frame_last;
    } life_result_t;

    life_result_t  expected_states[$];
    logic          upper_line [MAX_WIDTH];
    logic          middle_line [MAX_WIDTH];
    logic [2:0]    top_row, mid_row, bot_row;   // bit 2 holds the newest column
    int unsigned   col_pos, row_pos;
    lac_pkg::dim_t width_reg, height_reg;
    int            fail_count = 0;
    int            result_count = 0;

    function automatic int unsigned clamp_side(input lac_pkg::dim_t v, input int unsigned cap);
        if (v < MIN_SIDE) return MIN_SIDE;
        if (v > cap) return cap;
        return 32'(v);
    endfunction

    // Advance the window by one raster cell; returns 1 on an interior cell.
    function automatic bit next_generation(input logic arriving, output life_result_t res);
        int unsigned w, h, live;
        logic        from_upper, from_middle;
        bit          hit;
        w = clamp_side(width_reg, MAX_WIDTH);
        h = clamp_side(height_reg, ROWS_MAX);
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        from_upper  = upper_line[col_pos];
        from_middle = middle_line[col_pos];
        top_row = {from_upper, top_row[2:1]};
        mid_row = {from_middle, mid_row[2:1]};
        bot_row = {arriving, bot_row[2:1]};
        upper_line[col_pos]  = from_middle;
        middle_line[col_pos] = arriving;
        hit = 1'b0;
        res = '0;
        if (row_pos >= 2 && col_pos >= 2) begin
            live = $countones({top_row, mid_row[2], mid_row[0], bot_row});
            res.next_alive = (live == BORN_AT) || (mid_row[1] && live == KEEP_AT);
            res.frame_last = (row_pos == h - 1) && (col_pos == w - 1);
            hit = 1'b1;
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        return hit;
    endfunction

    always @(posedge aclk) begin
        life_result_t want;
        if (!aresetn) begin
            expected_states.delete();
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_line[i]  = 1'b0;
                middle_line[i] = 1'b0;
            end
            top_row = '0;
            mid_row = '0;
            bot_row = '0;
            col_pos = 0;
            row_pos = 0;
            width_reg  = lac_pkg::dim_t'(SIDE_AT_RESET);
            height_reg = lac_pkg::dim_t'(SIDE_AT_RESET);
        end else begin
            // any write to a grid register restarts the frame
            if (cfg_we) begin
                if (cfg_index == lac_pkg::REG_GRID_WIDTH) begin
                    width_reg = cfg_wdata;
                    col_pos = 0;
                    row_pos = 0;
                end else if (cfg_index == lac_pkg::REG_GRID_HEIGHT) begin
                    height_reg = cfg_wdata;
                    col_pos = 0;
                    row_pos = 0;
                end
            end
            if (s_valid && s_ready) begin
                if (next_generation(s_cell_alive, want)) expected_states.push_back(want);
            end
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_states.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result word with nothing expected: next_alive=%b last=%b",
                                 $realtime, m_next_alive, m_frame_last);
                end else begin
                    want = expected_states.pop_front();
                    if (m_next_alive !== want.next_alive || m_frame_last !== want.frame_last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("%0t: result %0d: expected next_alive=%b last=%b, got %b %b",
                                     $realtime, result_count, want.next_alive,
                                     want.frame_last, m_next_alive, m_frame_last);
                    end
                end
            end
        end
        outstanding     <= expected_states.size();
        mismatches      <= fail_count;
        results_checked <= result_count;
    end

endmodule

@@ test/life_automaton_stencil_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life automaton stencil testbench
// Streams padded grids of many sizes through the stencil, with random gaps on
// both channels, a long output stall, clamped and oversized grid sizes; the
// generation checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module life_automaton_stencil_tb;

    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 16;
    localparam int RANDOM_CELLS = 800;
    localparam lac_pkg::cfg_idx_t SPARE_REG_LO = lac_pkg::cfg_idx_t'(2);
    localparam lac_pkg::cfg_idx_t SPARE_REG_HI = lac_pkg::cfg_idx_t'(3);

    // raster order, first cell in the top bit
    localparam bit [15:0] GRID_4X4 = 16'b1100_0101_1000_0011;
    localparam bit [8:0]  GRID_3X3 = 9'b101_010_000;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    lac_pkg::cfg_idx_t cfg_index;
    lac_pkg::dim_t     cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic              s_cell_alive;
    logic              m_valid;
    logic              m_ready;
    logic              m_next_alive;
    logic              m_frame_last;

    int mismatches;
    int outstanding;
    int results_checked;
    int cells_sent = 0;
    int settings_used = 0;
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;
    bit hold_output = 1'b0;

    life_automaton_stencil dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_alive (s_cell_alive),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_alive (m_next_alive),
        .m_frame_last (m_frame_last)
    );

    life_generation_checker #(
        .MAX_WIDTH (1024)
    ) generation_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cell_alive    (s_cell_alive),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_next_alive    (m_next_alive),
        .m_frame_last    (m_frame_last),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results still outstanding", outstanding);
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random gaps per word, or a long hold when asked
    initial begin : result_sink
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = take_steady ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    task automatic offer_cell(input logic alive);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            s_cell_alive <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cell_alive <= alive;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cells_sent++;
    endtask

    // drop valid, wait for every expected word, then let border cells drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input lac_pkg::cfg_idx_t idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= lac_pkg::dim_t'(value);
        @(posedge aclk);
    endtask

    task automatic set_grid(input int w, input int h, input bit touch_w, input bit touch_h,
                            input bit spare);
        if (touch_w) write_reg(lac_pkg::REG_GRID_WIDTH, w);
        if (spare) write_reg($urandom_range(0, 1) ? SPARE_REG_HI : SPARE_REG_LO,
                             $urandom_range(0, 2047));
        if (touch_h) write_reg(lac_pkg::REG_GRID_HEIGHT, h);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic stream_cells(input int count, input int density);
        for (int i = 0; i < count; i++) offer_cell($urandom_range(0, 99) < density);
        settle();
    endtask

    initial begin
        int w, h, cur_w, cur_h, mode, count, density, random_start;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= lac_pkg::REG_GRID_WIDTH;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_cell_alive <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // small hand-built grid: survival and births
        set_grid(4, 4, 1'b1, 1'b1, 1'b0);
        for (int i = 15; i >= 0; i--) offer_cell(GRID_4X4[i]);
        settle();

        // sizes below the minimum clamp to 3x3; lone center survives on two
        set_grid(0, 2, 1'b1, 1'b1, 1'b0);
        for (int i = 8; i >= 0; i--) offer_cell(GRID_3X3[i]);
        settle();

        // hold the output long enough to back up the input, pause mid-frame
        set_grid(10, 10, 1'b1, 1'b1, 1'b1);
        send_steady = 1'b1;
        hold_output = 1'b1;
        for (int i = 0; i < 100; i++) begin
            if (i == 70) settle();
            offer_cell(1'($urandom_range(0, 1)));
        end
        settle();
        send_steady = 1'b0;

        // oversized height register: rows keep coming past the old size
        set_grid(3, 2047, 1'b1, 1'b1, 1'b0);
        stream_cells(3 * 80, 40);

        cur_w = 3;
        cur_h = 1024;
        random_start = cells_sent;
        while (cells_sent - random_start < RANDOM_CELLS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            mode = $urandom_range(0, 5);
            // leaving a register alone continues the current frame size
            if (cells_sent - random_start == 0) mode = 3;
            if (mode == 1 || mode >= 3) cur_w = (w < 3) ? 3 : w;
            if (mode == 2 || mode >= 3) cur_h = (h < 3) ? 3 : h;
            set_grid(w, h, mode == 1 || mode >= 3, mode == 2 || mode >= 3,
                     $urandom_range(0, 3) == 0);
            send_steady = ($urandom_range(0, 3) == 0);
            take_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, 2 * cur_w * cur_h);
            else
                count = $urandom_range(1, 3) * cur_w * cur_h;
            case ($urandom_range(0, 5))
                0:       density = 0;
                1:       density = 100;
                default: density = $urandom_range(10, 90);
            endcase
            stream_cells(count, density);
        end

        $display("Streamed %0d cells under %0d grid settings, %0d interior results checked",
                 cells_sent, settings_used, results_checked);
        $display("Grids ran from clamped 3x3 to oversized heights, with a long output stall");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/lac_pkg.sv
src/lac_front.sv
src/lac_queue.sv
src/lac_back.sv
src/life_automaton_stencil.sv
test/life_generation_checker.sv
test/life_automaton_stencil_tb.sv
